// ===== rtl/jddm_pkg.sv =====
`default_nettype none

package jddm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEADZONE   = 2'd0;
    localparam logic [1:0] CFG_SNAP_LEVEL = 2'd1;
    localparam logic [1:0] CFG_MIN_DUTY   = 2'd2;

    // Register values after reset.
    localparam logic [7:0] DEADZONE_RESET   = 8'd80;
    localparam logic [7:0] SNAP_LEVEL_RESET = 8'd230;
    localparam logic [7:0] MIN_DUTY_RESET   = 8'd35;

    // Magnitude limits of the cross-axis for straight runs and spot turns.
    localparam logic [7:0] FWD_LIMIT    = 8'd10;
    localparam logic [7:0] BACK_LIMIT   = 8'd20;
    localparam logic [7:0] TURN_R_LIMIT = 8'd40;
    localparam logic [7:0] TURN_L_LIMIT = 8'd20;

    // Full scale of one axis.
    localparam logic [7:0] FULL_SCALE = 8'd255;

    // Divisor of the sample-to-axis map.
    localparam logic [10:0] MAP_DIVISOR = 11'd1023;

    typedef logic signed [8:0] t_axis;

    typedef struct packed {
        logic [7:0] deadzone;
        logic [7:0] snap_level;
        logic [7:0] min_duty;
    } t_cfg;

    typedef struct packed {
        logic [7:0] right_duty;
        logic [7:0] left_duty;
        logic       right_dir;
        logic       left_dir;
    } t_drive;

endpackage

`default_nettype wire

// ===== rtl/joystick_differential_drive_mixer_top.sv =====
// Joystick differential-drive mixer.
// The slave stream takes one received joystick word per request; each request
// updates either the x or the y axis and yields exactly one drive result on
// the master stream: two direction levels and two 8-bit PWM compare values.
// The configuration channel writes deadzone (index 0), snap level (index 1)
// and minimum duty (index 2); it is always ready, and writes to other indexes
// are ignored. Write configuration only while no request is in flight.
// An accepted request passes through two registers to a valid result: one
// register after the sample-to-axis map, one result register after the mixer.
// Throughput is one request per cycle while results drain, set by the
// mixer's axis update, which feeds the stored axes back to the next request.
// When the receiver stalls, the result register holds its value and the map
// stage still takes one more request; o_s_axis_tready drops only when both
// stages are full. Reset clears both axes, the held drive outputs and all
// valid flags, and loads the default register values (80, 230, 35).
`default_nettype none

module joystick_differential_drive_mixer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream: [3:0] low_part, [9:4] high_part, [15:10] zero.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,
    // Master stream: [0] left_dir, [1] right_dir, [9:2] left_duty,
    // [17:10] right_duty, [23:18] zero.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    jddm_pkg::t_cfg   r_cfg;
    jddm_pkg::t_cfg   n_cfg;
    jddm_pkg::t_axis  r_axis;
    logic             r_axis_is_x;
    logic             r_map_valid;
    jddm_pkg::t_axis  r_x;
    jddm_pkg::t_axis  r_y;
    jddm_pkg::t_drive r_drive;
    logic             r_out_valid;

    jddm_pkg::t_axis  map_axis;
    jddm_pkg::t_axis  mix_x;
    jddm_pkg::t_axis  mix_y;
    jddm_pkg::t_drive mix_drive;
    logic             advance;
    logic             in_accept;
    logic             consume;

    // Pipeline control: the mixer stage moves when the result slot is free or drains.
    assign advance         = ~r_out_valid | i_m_axis_tready;
    assign consume         = r_map_valid & advance;
    assign o_s_axis_tready = ~r_map_valid | advance;
    assign in_accept       = i_s_axis_tvalid & o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Configuration register write.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                jddm_pkg::CFG_DEADZONE:   n_cfg.deadzone   = i_cfg_data;
                jddm_pkg::CFG_SNAP_LEVEL: n_cfg.snap_level = i_cfg_data;
                jddm_pkg::CFG_MIN_DUTY:   n_cfg.min_duty   = i_cfg_data;
                default:                  n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{deadzone:   jddm_pkg::DEADZONE_RESET,
                       snap_level: jddm_pkg::SNAP_LEVEL_RESET,
                       min_duty:   jddm_pkg::MIN_DUTY_RESET};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Sample-to-axis map on the incoming word.
    jddm_axis_map u_axis_map (
        .i_word (i_s_axis_tdata[9:0]),
        .o_axis (map_axis)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_map_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_axis      <= map_axis;
            r_axis_is_x <= i_s_axis_tdata[0];
        end
    end

    // Axis update, snap and drive rules.
    jddm_mixer u_mixer (
        .i_axis       (r_axis),
        .i_axis_is_x  (r_axis_is_x),
        .i_x_hold     (r_x),
        .i_y_hold     (r_y),
        .i_cfg        (r_cfg),
        .i_drive_hold (r_drive),
        .o_x          (mix_x),
        .o_y          (mix_y),
        .o_drive      (mix_drive)
    );

    // Stored axes and held drive, which is also the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_drive <= '0;
        end else if (consume) begin
            r_x     <= mix_x;
            r_y     <= mix_y;
            r_drive <= mix_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_map_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_drive.right_duty, r_drive.left_duty,
                              r_drive.right_dir, r_drive.left_dir};

endmodule

`default_nettype wire

// ===== rtl/jddm_axis_map.sv =====
`default_nettype none

// Maps a 10-bit joystick sample w to trunc((510*w - 255*1023) / 1023).
// The quotient 510*w / 1023 is estimated as a shift by ten and corrected
// with one compare and increment; negative results round toward zero.
module jddm_axis_map (
    input  wire logic [9:0]    i_word,
    output jddm_pkg::t_axis    o_axis
);

    logic [18:0] scaled;
    logic [8:0]  q_est;
    logic [10:0] r_est;
    logic        over;
    logic [8:0]  quot;
    logic        rem_nz;
    logic        round_up;
    logic [9:0]  sum;

    // 510*w as a shift-and-subtract.
    assign scaled = ({9'd0, i_word} << 9) - ({9'd0, i_word} << 1);

    // Estimate with 1024, then the remainder is low ten bits plus the estimate.
    assign q_est = scaled[18:10];
    assign r_est = {1'b0, scaled[9:0]} + {2'd0, q_est};
    assign over  = (r_est >= jddm_pkg::MAP_DIVISOR);
    assign quot  = q_est + {8'd0, over};
    assign rem_nz = over ? (r_est != jddm_pkg::MAP_DIVISOR) : (r_est != 11'd0);

    // Words below 512 give a negative numerator, which truncates upward.
    assign round_up = ~i_word[9] & rem_nz;
    assign sum = {1'b0, quot} - {2'd0, jddm_pkg::FULL_SCALE} + {9'd0, round_up};
    assign o_axis = sum[8:0];

endmodule

`default_nettype wire

// ===== rtl/jddm_mixer.sv =====
`default_nettype none

// Updates one axis, snaps both axes and applies the ordered drive rules.
// Purely combinational; the caller registers the axes and the drive.
module jddm_mixer (
    input  wire jddm_pkg::t_axis  i_axis,
    input  wire logic             i_axis_is_x,
    input  wire jddm_pkg::t_axis  i_x_hold,
    input  wire jddm_pkg::t_axis  i_y_hold,
    input  wire jddm_pkg::t_cfg   i_cfg,
    input  wire jddm_pkg::t_drive i_drive_hold,
    output jddm_pkg::t_axis       o_x,
    output jddm_pkg::t_axis       o_y,
    output jddm_pkg::t_drive      o_drive
);

    jddm_pkg::t_axis x_raw;
    jddm_pkg::t_axis y_raw;
    logic [7:0]      x_raw_mag;
    logic [7:0]      y_raw_mag;
    jddm_pkg::t_axis x;
    jddm_pkg::t_axis y;
    logic [7:0]      ax;
    logic [7:0]      ay;
    logic            x_pos;
    logic            x_neg;
    logic            y_pos;
    logic            y_neg;
    logic [7:0]      comp_x;
    logic [7:0]      comp_y;

    // The new sample replaces one axis.
    assign x_raw = i_axis_is_x ? i_axis : i_x_hold;
    assign y_raw = i_axis_is_x ? i_y_hold : i_axis;

    assign x_raw_mag = x_raw[8] ? 8'(-x_raw) : x_raw[7:0];
    assign y_raw_mag = y_raw[8] ? 8'(-y_raw) : y_raw[7:0];

    // Snap both axes to full scale beyond the snap level.
    always_comb begin
        x = x_raw;
        y = y_raw;
        if (x_raw_mag > i_cfg.snap_level) begin
            x = x_raw[8] ? -9'sd255 : 9'sd255;
        end
        if (y_raw_mag > i_cfg.snap_level) begin
            y = y_raw[8] ? -9'sd255 : 9'sd255;
        end
    end

    assign o_x = x;
    assign o_y = y;

    assign ax    = x[8] ? 8'(-x) : x[7:0];
    assign ay    = y[8] ? 8'(-y) : y[7:0];
    assign x_neg = x[8];
    assign y_neg = y[8];
    assign x_pos = ~x[8] & (x != 9'sd0);
    assign y_pos = ~y[8] & (y != 9'sd0);

    // Complement duties, dropped to zero below the minimum duty.
    assign comp_x = (~ax < i_cfg.min_duty) ? 8'd0 : ~ax;
    assign comp_y = (~ay < i_cfg.min_duty) ? 8'd0 : ~ay;

    // Ordered rules; with no match the previous drive is kept.
    always_comb begin
        o_drive = i_drive_hold;
        if (ax < i_cfg.deadzone && ay < i_cfg.deadzone) begin
            o_drive = '{right_duty: 8'd0, left_duty: 8'd0, right_dir: 1'b0, left_dir: 1'b0};
        end else if (ax < jddm_pkg::FWD_LIMIT && y_neg) begin
            o_drive = '{right_duty: ay, left_duty: ay, right_dir: 1'b1, left_dir: 1'b1};
        end else if (ax < jddm_pkg::BACK_LIMIT && y_pos) begin
            o_drive = '{right_duty: ay, left_duty: ay, right_dir: 1'b0, left_dir: 1'b0};
        end else if (ay < jddm_pkg::TURN_R_LIMIT && x_pos) begin
            o_drive = '{right_duty: ax, left_duty: ax, right_dir: 1'b0, left_dir: 1'b1};
        end else if (ay < jddm_pkg::TURN_L_LIMIT && x_neg) begin
            o_drive = '{right_duty: ax, left_duty: ax, right_dir: 1'b1, left_dir: 1'b0};
        end else if (x_pos && y_neg && ax >= ay) begin
            o_drive = '{right_duty: comp_y, left_duty: ax, right_dir: 1'b0, left_dir: 1'b1};
        end else if (x_pos && y_neg && ay > ax) begin
            o_drive = '{right_duty: comp_x, left_duty: ay, right_dir: 1'b1, left_dir: 1'b1};
        end else if (x_neg && y_neg && ay > ax) begin
            o_drive = '{right_duty: ay, left_duty: comp_x, right_dir: 1'b1, left_dir: 1'b1};
        end else if (x_neg && y_neg && ax >= ay) begin
            o_drive = '{right_duty: ax, left_duty: comp_y, right_dir: 1'b1, left_dir: 1'b0};
        end else if (x_neg && y_pos && ax > ay) begin
            o_drive = '{right_duty: comp_y, left_duty: ax, right_dir: 1'b1, left_dir: 1'b0};
        end else if (x_neg && y_pos && ay >= ax) begin
            o_drive = '{right_duty: comp_x, left_duty: ay, right_dir: 1'b0, left_dir: 1'b0};
        end else if (x_pos && y_pos && ay >= ax) begin
            o_drive = '{right_duty: ay, left_duty: comp_x, right_dir: 1'b0, left_dir: 1'b0};
        end else if (x_pos && y_pos && ax > ay) begin
            o_drive = '{right_duty: ax, left_duty: comp_y, right_dir: 1'b0, left_dir: 1'b1};
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jddm_checker.sv =====
`default_nettype none

module jddm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata
);

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // A stalled result is not withdrawn.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // Reset empties the result slot.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // A result out of an empty slot follows a request taken into the map register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(i_s_axis_tvalid && o_s_axis_tready, 2))
        else $error("result without a matching request");

    // The input side stalls only behind a stalled result.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid && !i_m_axis_tready)
        else $error("input stalled while output can drain");

endmodule

bind joystick_differential_drive_mixer_top jddm_checker u_jddm_checker (.*);

`default_nettype wire

// ===== tb/joystick_differential_drive_mixer_top_tb.sv =====
`default_nettype none

module joystick_differential_drive_mixer_top_tb;

    // Index that maps to no register; a write there must change nothing.
    localparam logic [1:0] CFG_SPARE = 2'd3;

    localparam int LONG_HOLD_CYCLES = 80;
    localparam int STALL_LIMIT      = 1000;
    localparam int RANDOM_PER_PHASE = 58;
    localparam int PHASE_COUNT      = 9;

    // Mirror of the mixer: stored axes, held drive outputs and the
    // configuration, plus the drive results still owed by the block.
    class drive_tracker;
        jddm_pkg::t_cfg   regs;
        int               x_pos;
        int               y_pos;
        jddm_pkg::t_drive held;
        jddm_pkg::t_drive expected_drives[$];
        int               failures;

        function new();
            regs.deadzone   = jddm_pkg::DEADZONE_RESET;
            regs.snap_level = jddm_pkg::SNAP_LEVEL_RESET;
            regs.min_duty   = jddm_pkg::MIN_DUTY_RESET;
            x_pos    = 0;
            y_pos    = 0;
            held     = '0;
            failures = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [7:0] data);
            case (idx)
                jddm_pkg::CFG_DEADZONE:   regs.deadzone   = data;
                jddm_pkg::CFG_SNAP_LEVEL: regs.snap_level = data;
                jddm_pkg::CFG_MIN_DUTY:   regs.min_duty   = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        // Axes beyond the snap level jump to full scale.
        function int snap_axis(int v);
            int s;
            int full;
            s    = regs.snap_level;
            full = jddm_pkg::FULL_SCALE;
            if (v > s) return full;
            if (v < -s) return -full;
            return v;
        endfunction

        // Duty of the slower wheel in an octet, floored to zero below min_duty.
        function int complement_duty(int v);
            int c;
            int floor_duty;
            floor_duty = regs.min_duty;
            c = int'(jddm_pkg::FULL_SCALE) - magnitude(v);
            if (c < floor_duty) c = 0;
            return c;
        endfunction

        function void set_drive(bit ld, bit rd, int lduty, int rduty);
            held.left_dir   = ld;
            held.right_dir  = rd;
            held.left_duty  = lduty[7:0];
            held.right_duty = rduty[7:0];
        endfunction

        // One accepted request: update an axis and run the ordered rules.
        function void note_request(logic [15:0] data);
            int word;
            int axis_val;
            int x, y, ax, ay, dz;
            int fwd_lim, back_lim, turn_r_lim, turn_l_lim;
            word       = data[9:0];
            fwd_lim    = jddm_pkg::FWD_LIMIT;
            back_lim   = jddm_pkg::BACK_LIMIT;
            turn_r_lim = jddm_pkg::TURN_R_LIMIT;
            turn_l_lim = jddm_pkg::TURN_L_LIMIT;
            axis_val   = (word * 510 - 260865) / int'(jddm_pkg::MAP_DIVISOR);
            if (word[0]) x_pos = axis_val;
            else y_pos = axis_val;
            x_pos = snap_axis(x_pos);
            y_pos = snap_axis(y_pos);
            x  = x_pos;
            y  = y_pos;
            ax = magnitude(x);
            ay = magnitude(y);
            dz = regs.deadzone;

            if (ax < dz && ay < dz) set_drive(0, 0, 0, 0);
            else if (ax < fwd_lim && y < 0) set_drive(1, 1, ay, ay);
            else if (ax < back_lim && y > 0) set_drive(0, 0, ay, ay);
            else if (ay < turn_r_lim && x > 0) set_drive(1, 0, ax, ax);
            else if (ay < turn_l_lim && x < 0) set_drive(0, 1, ax, ax);
            else if (x > 0 && y < 0 && x >= ay) set_drive(1, 0, x, complement_duty(y));
            else if (x > 0 && y < 0 && ay > x) set_drive(1, 1, ay, complement_duty(x));
            else if (x < 0 && y < 0 && ay > ax) set_drive(1, 1, complement_duty(x), ay);
            else if (x < 0 && y < 0 && ax >= ay) set_drive(0, 1, complement_duty(y), ax);
            else if (x < 0 && y > 0 && ax > y) set_drive(0, 1, ax, complement_duty(y));
            else if (x < 0 && y > 0 && y >= ax) set_drive(0, 0, y, complement_duty(x));
            else if (x > 0 && y > 0 && y >= x) set_drive(0, 0, complement_duty(x), y);
            else if (x > 0 && y > 0 && x > y) set_drive(1, 0, complement_duty(y), x);
            // With no rule matching, the held drive is repeated.
            expected_drives.push_back(held);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_drive(logic [23:0] data);
            jddm_pkg::t_drive want;
            jddm_pkg::t_drive got;
            got = jddm_pkg::t_drive'(data[17:0]);
            if (expected_drives.size() == 0) begin
                $display("%0t: result with none expected, expected none, actual %h",
                         $time, data);
                failures++;
                return;
            end
            want = expected_drives.pop_front();
            compare_field("left_dir", want.left_dir, got.left_dir);
            compare_field("right_dir", want.right_dir, got.right_dir);
            compare_field("left_duty", want.left_duty, got.left_duty);
            compare_field("right_duty", want.right_duty, got.right_duty);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    drive_tracker tracker;
    bit           no_idle = 1'b0;
    bit           long_hold_req = 1'b0;
    int           quiet_cycles = 0;

    joystick_differential_drive_mixer_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Monitor all three channels and watch for a stalled run.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) tracker.check_drive(o_m_axis_tdata);
            if (i_s_axis_tvalid && o_s_axis_tready) tracker.note_request(i_s_axis_tdata);
            if (i_cfg_valid && o_cfg_ready) tracker.write_register(i_cfg_index, i_cfg_data);
            if ((o_m_axis_tvalid && i_m_axis_tready) || (i_s_axis_tvalid && o_s_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stalls per result, and one long hold-off on request.
    initial begin
        int stall;
        forever begin
            if (long_hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                long_hold_req = 1'b0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
        end
    end

    // Offer one joystick word and hold it until the block takes it.
    task automatic send_word(input logic [9:0] word);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, word};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves the write channel valid; the caller lowers it after the last write.
    task automatic write_config(input logic [1:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic program_registers(input logic [7:0] dz, input logic [7:0] snap_lvl,
                                     input logic [7:0] floor_duty, input bit poke_spare);
        wait_idle();
        write_config(jddm_pkg::CFG_DEADZONE, dz);
        write_config(jddm_pkg::CFG_SNAP_LEVEL, snap_lvl);
        write_config(jddm_pkg::CFG_MIN_DUTY, floor_duty);
        if (poke_spare) write_config(CFG_SPARE, 8'($urandom_range(0, 255)));
        i_cfg_valid <= 1'b0;
    endtask

    // Half full-range words, half weighted near center, the ends and
    // the deadzone edge.
    function automatic logic [9:0] draw_word();
        int a;
        int w;
        case ($urandom_range(0, 5))
            2: w = 511 + $urandom_range(0, 40) - 20;
            3: w = $urandom_range(0, 1) ? $urandom_range(0, 40) : 1023 - $urandom_range(0, 40);
            4: begin
                a = int'(tracker.regs.deadzone) + $urandom_range(0, 12) - 6;
                w = $urandom_range(0, 1) ? 512 + 2 * a : 511 - 2 * a;
            end
            default: w = $urandom_range(0, 1023);
        endcase
        if (w < 0) w = 0;
        if (w > 1023) w = 1023;
        return w[9:0];
    endfunction

    initial begin
        logic [9:0] directed_words[$];
        tracker = new();
        // Ends of both axes, stop, forward, backward, spot turns, all eight
        // octets, then the ends again.
        directed_words = '{10'd0, 10'd1023, 10'd1, 10'd1022, 10'd511, 10'd512,
                           10'd511, 10'd0, 10'd1022, 10'd512, 10'd1023, 10'd1,
                           10'd911, 10'd312, 10'd50, 10'd111, 10'd312, 10'd712,
                           10'd972, 10'd911, 10'd712, 10'd1023, 10'd0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[i]) send_word(directed_words[i]);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: ;
                1: program_registers(8'd0, 8'd255, 8'd0, 1'b1);
                2: program_registers(8'd255, 8'd0, 8'd255, 1'b0);
                3: program_registers(8'd0, 8'd0, 8'd255, 1'b1);
                4: program_registers(8'd255, 8'd255, 8'd0, 1'b0);
                5: program_registers(8'd10, 8'd200, 8'd60, 1'b0);
                default: program_registers(8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)),
                                           8'($urandom_range(0, 255)), 1'b1);
            endcase
            // Both axes centered: a stop, or a held drive with no deadzone.
            send_word(10'd511);
            send_word(10'd512);
            if (phase == 1 || phase == 5) begin
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                no_idle = (phase % 2 == 1) && (n < 25);
                send_word(draw_word());
            end
            no_idle = 1'b0;
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
